// ===== hdl/sphere_triangle_subdivider_macros.svh =====
// assertion macros for the sphere triangle subdivider
// each macro samples on clk and is disabled while arst_n is low
`ifndef SPHERE_TRIANGLE_SUBDIVIDER_MACROS_SVH
`define SPHERE_TRIANGLE_SUBDIVIDER_MACROS_SVH

// same-cycle implication
`define STSUB_ASSERT_IMP(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) else $error(msg);

// next-cycle implication
`define STSUB_ASSERT_NXT(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) else $error(msg);

`endif

// ===== hdl/stsub_pkg.sv =====
// ----------------------------------------------------------------------------
// stsub_pkg
// types, widths and state codes shared by the subdivider modules
// ----------------------------------------------------------------------------
package stsub_pkg;

	localparam int COORD_BITS  = 16;
	localparam int IDX_BITS    = 16;
	localparam int RAD_BITS    = 15;
	localparam int MAG_BITS    = 17;
	localparam int PROD_BITS   = 34;
	localparam int LEN_BITS    = 34;
	localparam int ROOT_BITS   = 29;
	localparam int NUM_BITS    = 45;
	localparam int QUO_BITS    = 17;
	localparam int REM_BITS    = 33;
	localparam int SH_BITS     = 58;
	localparam int SQRT_STEPS  = 29;
	localparam int DIV_STEPS   = 17;
	localparam int NUM_RESULTS = 7;

	localparam logic [RAD_BITS-1:0] RADIUS_RESET = 15'd8192;
	localparam logic [COORD_BITS-1:0] COORD_POS_MAX = 16'h7fff;
	localparam logic [COORD_BITS-1:0] COORD_NEG_MIN = 16'h8000;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [IDX_BITS-1:0] index_t;

	typedef struct packed {
		index_t corner0_index;
		index_t corner1_index;
		index_t corner2_index;
		coord_t corner0_x;
		coord_t corner0_y;
		coord_t corner0_z;
		coord_t corner1_x;
		coord_t corner1_y;
		coord_t corner1_z;
		coord_t corner2_x;
		coord_t corner2_y;
		coord_t corner2_z;
	} in_item_t;

	typedef struct packed {
		logic   is_triangle;
		index_t vertex_index;
		coord_t vertex_x;
		coord_t vertex_y;
		coord_t vertex_z;
		index_t tri_first;
		index_t tri_second;
		index_t tri_third;
		logic   index_overflow;
		logic   last;
	} out_item_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vec_t;

	typedef enum logic [1:0] {
		STEP_SQRT,
		STEP_DIV
	} step_mode_t;

	typedef enum logic [3:0] {
		C_IDLE,
		C_SUM,
		C_SQ,
		C_ACC,
		C_SQRT,
		C_MUL,
		C_CHK,
		C_DIV,
		C_STORE,
		C_DONE
	} core_state_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_START,
		T_WAIT,
		T_EMIT
	} top_state_t;

endpackage

// ===== hdl/sphere_triangle_subdivider.sv =====
// one triangle at a time: no new triangle is taken until its last result is loaded into the output register
// each triangle gives 7 results, and output stalls hold them back
// per edge: 29 root steps and up to 3 x 17 divide steps in the shared step unit plus setup
// reset (arst_n low): radius back to 1.0, vertex counter back to 4, no item in flight
// ----------------------------------------------------------------------------
// sphere_triangle_subdivider
// splits one triangle into four, projecting edge midpoints onto a sphere
// ----------------------------------------------------------------------------
`include "sphere_triangle_subdivider_macros.svh"

module sphere_triangle_subdivider #(
	parameter int MAX_VERTICES = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// triangle input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  stsub_pkg::in_item_t  in_data,
	// result output channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output stsub_pkg::out_item_t out_data,
	// radius register write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [14:0]          cfg_data
);

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_VERTICES);
	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(4);
	localparam logic [31:0]      IDX_SAT   = 32'(MAX_VERTICES - 1);

	stsub_pkg::top_state_t state_q, state_d;

	logic [stsub_pkg::RAD_BITS-1:0] radius_q;
	logic [CNT_W-1:0]               next_q;
	stsub_pkg::in_item_t            tri_q;
	stsub_pkg::vec_t                pos_q [3];
	stsub_pkg::index_t              mid_q [3];
	logic [1:0]                     edge_q;
	logic [2:0]                     res_q;
	logic                           ovf_q;
	logic                           out_valid_q;
	stsub_pkg::out_item_t           out_q;

	stsub_pkg::vec_t   corner [3];
	stsub_pkg::vec_t   pa, pb, core_res;
	logic              core_start, core_done;
	logic              in_xfer, out_free;
	logic [31:0]       next_w;
	stsub_pkg::out_item_t emit;

	// config register takes a write whenever offered
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) radius_q <= stsub_pkg::RADIUS_RESET;
		else if (cfg_valid && cfg_ready) radius_q <= cfg_data;
	end

	// one triangle at a time: input is held off from transfer to last result load
	assign in_stall = (state_q != stsub_pkg::T_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		corner[0] = '{x: tri_q.corner0_x, y: tri_q.corner0_y, z: tri_q.corner0_z};
		corner[1] = '{x: tri_q.corner1_x, y: tri_q.corner1_y, z: tri_q.corner1_z};
		corner[2] = '{x: tri_q.corner2_x, y: tri_q.corner2_y, z: tri_q.corner2_z};
	end

	// edges c0-c1, c1-c2, c2-c0
	always_comb begin
		case (edge_q)
			2'd0:    begin pa = corner[0]; pb = corner[1]; end
			2'd1:    begin pa = corner[1]; pb = corner[2]; end
			default: begin pa = corner[2]; pb = corner[0]; end
		endcase
	end

	assign core_start = (state_q == stsub_pkg::T_START);

	stsub_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (core_start),
		.pa     (pa),
		.pb     (pb),
		.radius (radius_q),
		.done   (core_done),
		.res    (core_res)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			stsub_pkg::T_IDLE:  if (in_xfer) state_d = stsub_pkg::T_START;
			stsub_pkg::T_START: state_d = stsub_pkg::T_WAIT;
			stsub_pkg::T_WAIT: begin
				if (core_done) state_d = (edge_q == 2'd2) ? stsub_pkg::T_EMIT : stsub_pkg::T_START;
			end
			stsub_pkg::T_EMIT: begin
				if (out_free && res_q == 3'(stsub_pkg::NUM_RESULTS - 1)) state_d = stsub_pkg::T_IDLE;
			end
			default: state_d = stsub_pkg::T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= stsub_pkg::T_IDLE;
		else state_q <= state_d;
	end

	// vertex counter saturates at MAX_VERTICES, one past the index range end
	assign next_w = 32'(next_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q <= CNT_RESET;
		end else if (state_q == stsub_pkg::T_WAIT && core_done && next_q < CNT_MAX) begin
			next_q <= next_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			tri_q  <= in_data;
			edge_q <= 2'd0;
			res_q  <= 3'd0;
			ovf_q  <= 1'b0;
		end
		if (state_q == stsub_pkg::T_WAIT && core_done) begin
			pos_q[edge_q] <= core_res;
			if (next_q >= CNT_MAX) begin
				mid_q[edge_q] <= IDX_SAT[15:0];
				ovf_q         <= 1'b1;
			end else begin
				mid_q[edge_q] <= next_w[15:0];
			end
			edge_q <= edge_q + 2'd1;
		end
		if (state_q == stsub_pkg::T_EMIT && out_free) res_q <= res_q + 3'd1;
	end

	// result mux: three vertices, then children (c0,m01,m20) (m01,c1,m12) (m01,m12,m20) (c2,m20,m12)
	always_comb begin
		emit = '0;
		emit.index_overflow = ovf_q;
		emit.last = (res_q == 3'(stsub_pkg::NUM_RESULTS - 1));
		case (res_q)
			3'd0, 3'd1, 3'd2: begin
				emit.vertex_index = mid_q[res_q[1:0]];
				emit.vertex_x     = pos_q[res_q[1:0]].x;
				emit.vertex_y     = pos_q[res_q[1:0]].y;
				emit.vertex_z     = pos_q[res_q[1:0]].z;
			end
			3'd3: begin
				emit.is_triangle = 1'b1;
				emit.tri_first   = tri_q.corner0_index;
				emit.tri_second  = mid_q[0];
				emit.tri_third   = mid_q[2];
			end
			3'd4: begin
				emit.is_triangle = 1'b1;
				emit.tri_first   = mid_q[0];
				emit.tri_second  = tri_q.corner1_index;
				emit.tri_third   = mid_q[1];
			end
			3'd5: begin
				emit.is_triangle = 1'b1;
				emit.tri_first   = mid_q[0];
				emit.tri_second  = mid_q[1];
				emit.tri_third   = mid_q[2];
			end
			default: begin
				emit.is_triangle = 1'b1;
				emit.tri_first   = tri_q.corner2_index;
				emit.tri_second  = mid_q[2];
				emit.tri_third   = mid_q[1];
			end
		endcase
	end

	// output register, refilled whenever the held result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == stsub_pkg::T_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && state_q == stsub_pkg::T_EMIT) out_q <= emit;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	`STSUB_ASSERT_NXT(a_busy_after_xfer, in_xfer, in_stall, "input taken while busy")
	`STSUB_ASSERT_IMP(a_done_in_wait, core_done, state_q == stsub_pkg::T_WAIT, "core done outside wait")
	`STSUB_ASSERT_IMP(a_cnt_bound, 1'b1, next_q <= CNT_MAX, "vertex counter past range")
	`STSUB_ASSERT_IMP(a_tri_fields, out_valid && out_data.is_triangle, out_data.vertex_index == '0, "triangle carries vertex index")

endmodule

// ===== hdl/stsub_step.sv =====
// ----------------------------------------------------------------------------
// stsub_step
// shared shift, compare and subtract step for root and divide iterations
// ----------------------------------------------------------------------------
module stsub_step (
	input  stsub_pkg::step_mode_t            mode,
	input  logic [stsub_pkg::REM_BITS-1:0]   rem_in,
	input  logic [1:0]                       bits_in,
	input  logic [stsub_pkg::REM_BITS-1:0]   sub_in,
	output logic [stsub_pkg::REM_BITS-1:0]   rem_out,
	output logic                             ge
);

	logic [stsub_pkg::REM_BITS-1:0] x;
	logic [stsub_pkg::REM_BITS:0]   diff;

	always_comb begin
		case (mode)
			stsub_pkg::STEP_SQRT: x = {rem_in[stsub_pkg::REM_BITS-3:0], bits_in};
			default:              x = {rem_in[stsub_pkg::REM_BITS-2:0], bits_in[1]};
		endcase
		diff    = {1'b0, x} - {1'b0, sub_in};
		ge      = ~diff[stsub_pkg::REM_BITS];
		rem_out = ge ? diff[stsub_pkg::REM_BITS-1:0] : x;
	end

endmodule

// ===== hdl/stsub_core.sv =====
// ----------------------------------------------------------------------------
// stsub_core
// projects the sum of two corners onto the sphere with one shared step unit
// ----------------------------------------------------------------------------
module stsub_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  stsub_pkg::vec_t                   pa,
	input  stsub_pkg::vec_t                   pb,
	input  logic [stsub_pkg::RAD_BITS-1:0]    radius,
	output logic                              done,
	output stsub_pkg::vec_t                   res
);

	stsub_pkg::core_state_t state_q, state_d;

	logic [stsub_pkg::MAG_BITS-1:0]  mag_q [3];
	logic [2:0]                      neg_q;
	logic [1:0]                      k_q;
	logic [4:0]                      step_q;
	logic [stsub_pkg::PROD_BITS-1:0] prod_q;
	logic [stsub_pkg::LEN_BITS-1:0]  len_q;
	logic [stsub_pkg::ROOT_BITS-1:0] root_q;
	logic [stsub_pkg::REM_BITS-1:0]  rem_q;
	logic [stsub_pkg::SH_BITS-1:0]   sh_q;
	logic [stsub_pkg::QUO_BITS-1:0]  quo_q;
	logic                            sat_q;
	logic [stsub_pkg::COORD_BITS-1:0] res_q [3];

	logic signed [stsub_pkg::MAG_BITS-1:0] sum [3];
	logic [stsub_pkg::MAG_BITS-1:0]  mul_b;
	logic [stsub_pkg::PROD_BITS-1:0] mul_p;
	logic [stsub_pkg::LEN_BITS-1:0]  len_new;
	logic [stsub_pkg::NUM_BITS-1:0]  num;
	logic                            num_big;
	stsub_pkg::step_mode_t           mode;
	logic [1:0]                      st_bits;
	logic [stsub_pkg::REM_BITS-1:0]  st_sub;
	logic [stsub_pkg::REM_BITS-1:0]  st_rem;
	logic                            st_ge;
	logic [stsub_pkg::COORD_BITS-1:0] out_val;
	logic [stsub_pkg::QUO_BITS-1:0]  neg_m;

	always_comb begin
		sum[0] = 17'(pa.x) + 17'(pb.x);
		sum[1] = 17'(pa.y) + 17'(pb.y);
		sum[2] = 17'(pa.z) + 17'(pb.z);
	end

	// shared multiplier: squares first, then magnitude times radius
	assign mul_b   = (state_q == stsub_pkg::C_SQ) ? mag_q[k_q] : {2'b00, radius};
	assign mul_p   = 34'(mag_q[k_q]) * 34'(mul_b);
	assign len_new = len_q + prod_q;
	assign num     = {prod_q[31:0], 12'd0} + 45'(root_q[stsub_pkg::ROOT_BITS-1:1]);
	assign num_big = {1'b0, num} >= {root_q, 17'd0};

	always_comb begin
		if (state_q == stsub_pkg::C_SQRT) begin
			mode    = stsub_pkg::STEP_SQRT;
			st_bits = sh_q[stsub_pkg::SH_BITS-1 -: 2];
			st_sub  = 33'({root_q, 2'b01});
		end else begin
			mode    = stsub_pkg::STEP_DIV;
			st_bits = {sh_q[stsub_pkg::SH_BITS-1], 1'b0};
			st_sub  = 33'(root_q);
		end
	end

	stsub_step u_step (
		.mode    (mode),
		.rem_in  (rem_q),
		.bits_in (st_bits),
		.sub_in  (st_sub),
		.rem_out (st_rem),
		.ge      (st_ge)
	);

	// rounded quotient to a saturated signed coordinate
	always_comb begin
		neg_m = 17'd0 - quo_q;
		if (neg_q[k_q]) begin
			out_val = (sat_q || quo_q > 17'd32768) ? stsub_pkg::COORD_NEG_MIN : neg_m[15:0];
		end else begin
			out_val = (sat_q || quo_q > 17'd32767) ? stsub_pkg::COORD_POS_MAX : quo_q[15:0];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			stsub_pkg::C_IDLE:  if (start) state_d = stsub_pkg::C_SUM;
			stsub_pkg::C_SUM:   state_d = stsub_pkg::C_SQ;
			stsub_pkg::C_SQ:    state_d = stsub_pkg::C_ACC;
			stsub_pkg::C_ACC:   state_d = (k_q == 2'd2) ? stsub_pkg::C_SQRT : stsub_pkg::C_SQ;
			stsub_pkg::C_SQRT:  if (step_q == 5'd0) state_d = stsub_pkg::C_MUL;
			stsub_pkg::C_MUL:   state_d = stsub_pkg::C_CHK;
			stsub_pkg::C_CHK: begin
				if (root_q == '0 || num_big) state_d = stsub_pkg::C_STORE;
				else state_d = stsub_pkg::C_DIV;
			end
			stsub_pkg::C_DIV:   if (step_q == 5'd0) state_d = stsub_pkg::C_STORE;
			stsub_pkg::C_STORE: state_d = (k_q == 2'd2) ? stsub_pkg::C_DONE : stsub_pkg::C_MUL;
			stsub_pkg::C_DONE:  state_d = stsub_pkg::C_IDLE;
			default:            state_d = stsub_pkg::C_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= stsub_pkg::C_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (state_q)
			stsub_pkg::C_SUM: begin
				for (int i = 0; i < 3; i++) begin
					neg_q[i] <= sum[i][16];
					mag_q[i] <= sum[i][16] ? 17'(-sum[i]) : 17'(sum[i]);
				end
				len_q <= '0;
				k_q   <= 2'd0;
			end
			stsub_pkg::C_ACC: begin
				len_q <= len_new;
				if (k_q == 2'd2) begin
					sh_q   <= {len_new, 24'd0};
					rem_q  <= '0;
					root_q <= '0;
					step_q <= 5'(stsub_pkg::SQRT_STEPS - 1);
					k_q    <= 2'd0;
				end else begin
					k_q <= k_q + 2'd1;
				end
			end
			stsub_pkg::C_SQRT: begin
				rem_q  <= st_rem;
				root_q <= {root_q[stsub_pkg::ROOT_BITS-2:0], st_ge};
				sh_q   <= {sh_q[stsub_pkg::SH_BITS-3:0], 2'b00};
				step_q <= step_q - 5'd1;
			end
			stsub_pkg::C_CHK: begin
				sat_q  <= num_big;
				quo_q  <= '0;
				rem_q  <= 33'(num[44:17]);
				sh_q   <= {num[16:0], 41'd0};
				step_q <= 5'(stsub_pkg::DIV_STEPS - 1);
				if (root_q == '0) res_q[k_q] <= '0;
			end
			stsub_pkg::C_DIV: begin
				rem_q  <= st_rem;
				quo_q  <= {quo_q[stsub_pkg::QUO_BITS-2:0], st_ge};
				sh_q   <= {sh_q[stsub_pkg::SH_BITS-2:0], 1'b0};
				step_q <= step_q - 5'd1;
			end
			stsub_pkg::C_STORE: begin
				if (root_q != '0) res_q[k_q] <= out_val;
				k_q <= k_q + 2'd1;
			end
			default: ;
		endcase
	end

	assign done  = (state_q == stsub_pkg::C_DONE);
	assign res.x = res_q[0];
	assign res.y = res_q[1];
	assign res.z = res_q[2];

endmodule
